// ----- rtl/irbt_pkg.sv -----
`timescale 1ns / 1ps
package irbt_pkg;
	typedef enum logic [2:0] {
		OP_LESS       = 3'd0,
		OP_LESS_EQ    = 3'd1,
		OP_GREATER    = 3'd2,
		OP_GREATER_EQ = 3'd3,
		OP_EQ         = 3'd4
	} op_t;

	localparam logic [1:0] KIND_INT    = 2'd0;
	localparam logic [1:0] KIND_DOUBLE = 2'd1;

	localparam logic [0:0] REG_LOW  = 1'b0;
	localparam logic [0:0] REG_HIGH = 1'b1;

	// 2^53 as a signed 64-bit integer
	localparam logic signed [63:0] SAT_LIMIT = 64'sd9007199254740992;

	// classified comparison handed from front to back
	typedef struct packed {
		logic        fail;     // item fails the run
		logic        skip;     // item changes nothing
		logic [2:0]  op;
		logic [63:0] v;        // non-negative bound
		logic        last;
	} cmd_t;
endpackage

// ----- rtl/irbt_if.sv -----
`timescale 1ns / 1ps
interface irbt_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  opcode;
	logic [1:0]  value_kind;
	logic [63:0] bound_bits;
	logic        has_bound;
	logic        last;
	modport source (output valid, opcode, value_kind, bound_bits, has_bound, last,
		input ready);
	modport sink (input valid, opcode, value_kind, bound_bits, has_bound, last,
		output ready);
endinterface

interface irbt_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] range_low;
	logic [63:0] range_high;
	logic        nonempty;
	modport source (output valid, range_low, range_high, nonempty, input ready);
	modport sink (input valid, range_low, range_high, nonempty, output ready);
endinterface

// ----- rtl/irbt_front.sv -----
`timescale 1ns / 1ps
module irbt_front import irbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	irbt_in_if.sink     in_ch,
	output logic        cmd_valid,
	input  logic        cmd_ready,
	output cmd_t        cmd
);
	logic        vld_s1;
	cmd_t        cmd_s1;
	logic [2:0]  op;
	logic [63:0] b;
	logic        sgn;
	logic [10:0] ex;
	logic [51:0] fr;
	logic        nan;
	logic signed [63:0] t;
	logic        frac;
	logic signed [63:0] bound;
	logic        bad;
	cmd_t        c;
	logic [52:0] mant;
	logic [63:0] mag;
	logic [63:0] lost;
	logic [6:0]  sh;

	assign op = in_ch.opcode;
	assign b  = in_ch.bound_bits;
	assign sgn = b[63];
	assign ex  = b[62:52];
	assign fr  = b[51:0];
	assign nan = (ex == 11'h7ff) && (fr != '0);

	// truncate the double toward zero, note any dropped fraction
	always_comb begin
		mant = {(ex != 11'd0), fr};
		mag  = '0;
		lost = '0;
		sh   = '0;
		frac = 1'b0;
		if (ex >= 11'd1076) begin
			mag = 64'(SAT_LIMIT);          // 2^53 or more: saturate
		end else if (ex >= 11'd1075) begin
			mag = {11'd0, mant};
		end else if (ex >= 11'd1023) begin
			sh   = 7'(11'd1075 - ex);
			mag  = {11'd0, mant} >> sh;
			lost = {11'd0, mant} & ((64'd1 << sh) - 64'd1);
			frac = lost != '0;
		end else begin
			frac = b[62:0] != '0;
		end
		t = sgn ? -$signed(mag) : $signed(mag);
	end

	always_comb begin
		bad   = 1'b0;
		bound = $signed(b);
		if (in_ch.value_kind == KIND_DOUBLE) begin
			bound = t;
			if (nan) bad = 1'b1;
			if (frac) begin
				unique case (op)
					OP_LESS, OP_GREATER_EQ: if (!sgn) bound = t + 64'sd1;
					OP_LESS_EQ, OP_GREATER: if (sgn) bound = t - 64'sd1;
					OP_EQ: bad = 1'b1;
					default: ;
				endcase
			end
		end else if (in_ch.value_kind != KIND_INT) begin
			bad = 1'b1;
		end
		if (op > OP_EQ) bad = 1'b1;
		c.op   = op;
		c.v    = 64'(bound);
		c.last = in_ch.last;
		c.fail = 1'b0;
		c.skip = !in_ch.has_bound;
		if (in_ch.has_bound) begin
			if (bad) begin
				c.fail = 1'b1;
			end else if (bound < 0 || (bound == 0 && op == OP_LESS)) begin
				if (op == OP_GREATER || op == OP_GREATER_EQ) c.skip = 1'b1;
				else c.fail = 1'b1;
			end
		end
	end

	assign in_ch.ready = !vld_s1 || cmd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) cmd_s1 <= c;
	end

	assign cmd_valid = vld_s1;
	assign cmd = cmd_s1;
endmodule

// ----- rtl/irbt_fifo.sv -----
`timescale 1ns / 1ps
module irbt_fifo import irbt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  cmd_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output cmd_t rd_data
);
	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign wr_ready = cnt_q != 2'd2;
	assign rd_valid = cnt_q != 2'd0;
	assign rd_data  = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + 2'(wr) - 2'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

`ifndef SYNTH
	a_no_over: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd2 |-> !wr) else $error("queue overflow");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q != 2'd3) else $error("bad count");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rd_valid && !rd_ready && !wr |=> $stable(cnt_q)) else $error("count moved");
`endif
endmodule

// ----- rtl/irbt_back.sv -----
`timescale 1ns / 1ps
module irbt_back import irbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	input  logic [63:0] init_low,
	input  logic [63:0] init_high,
	irbt_out_if.source  out_ch
);
	logic [63:0] low_q, high_q, lo, hi, nlo, nhi;
	logic        fail_q, in_run_q, f, nf;
	logic        ovld_q;
	logic [63:0] olow_q, ohigh_q;
	logic        one_q;
	logic        go;

	assign cmd_ready = !ovld_q || out_ch.ready;
	assign go = cmd_valid && cmd_ready;
	assign lo = in_run_q ? low_q : init_low;
	assign hi = in_run_q ? high_q : init_high;
	assign f  = in_run_q && fail_q;

	always_comb begin
		nlo = lo;
		nhi = hi;
		nf  = f;
		if (!f && !cmd.skip) begin
			if (cmd.fail) begin
				nf = 1'b1;
			end else begin
				unique case (cmd.op)
					OP_LESS:       if (hi >= cmd.v) nhi = cmd.v - 64'd1;
					OP_LESS_EQ:    if (hi > cmd.v) nhi = cmd.v;
					OP_GREATER:    if (lo <= cmd.v) nlo = cmd.v + 64'd1;
					OP_GREATER_EQ: if (lo < cmd.v) nlo = cmd.v;
					default: begin
						if (cmd.v < lo || cmd.v > hi) nf = 1'b1;
						else begin
							nlo = cmd.v;
							nhi = cmd.v;
						end
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_run_q <= 1'b0;
			fail_q   <= 1'b0;
			ovld_q   <= 1'b0;
		end else begin
			if (out_ch.ready) ovld_q <= 1'b0;
			if (go) begin
				in_run_q <= !cmd.last;
				fail_q   <= nf;
				if (cmd.last) ovld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			low_q  <= nlo;
			high_q <= nhi;
			if (cmd.last) begin
				olow_q  <= nf ? 64'd0 : nlo;
				ohigh_q <= nf ? 64'd0 : nhi;
				one_q   <= !nf && (nlo <= nhi);
			end
		end
	end

	assign out_ch.valid      = ovld_q;
	assign out_ch.range_low  = olow_q;
	assign out_ch.range_high = ohigh_q;
	assign out_ch.nonempty   = one_q;

`ifndef SYNTH
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !out_ch.ready |-> !cmd_ready) else $error("result overwritten");
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ovld_q && !one_q && olow_q != ohigh_q |-> olow_q > ohigh_q)
		else $error("empty result inconsistent");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		go && cmd.last |=> !in_run_q) else $error("run not closed");
`endif
endmodule

// ----- rtl/id_range_bound_tightener.sv -----
`timescale 1ns / 1ps
// Tightens an unsigned id interval [initial_low, initial_high] over a run of
// comparison requests (integer or double bounds) and delivers one result per
// request marked last. One request is taken per cycle when nothing stalls: a
// front stage decodes and rounds the bound in one registered step, and a
// two-entry queue decouples it from the back stage, which updates the interval.
// The result register loads after the last request leaves the front register
// and the queue. Write initial_low at byte 0 and initial_high at byte 8 only
// while idle; a write takes effect at the next run.
module id_range_bound_tightener import irbt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	irbt_in_if.sink     in_ch,
	irbt_out_if.source  out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready
);
	cmd_t        f_cmd, b_cmd;
	logic        f_valid, f_ready, b_valid, b_ready;
	logic [63:0] init_low_q, init_high_q;

	assign pready = 1'b1;

	// register file: hold limits between runs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_low_q  <= '0;
			init_high_q <= '1;
		end else if (psel && penable && pwrite && paddr[2:0] == 3'd0) begin
			unique case (paddr[3])
				REG_LOW:  init_low_q  <= pwdata;
				REG_HIGH: init_high_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2:0] == 3'd0) prdata = paddr[3] ? init_high_q : init_low_q;
	end

	irbt_front u_front (.clk, .arst_n, .in_ch,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd));

	irbt_fifo u_fifo (.clk, .arst_n, .wr_valid(f_valid), .wr_ready(f_ready),
		.wr_data(f_cmd), .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_cmd));

	irbt_back u_back (.clk, .arst_n, .cmd_valid(b_valid), .cmd_ready(b_ready),
		.cmd(b_cmd), .init_low(init_low_q), .init_high(init_high_q), .out_ch);
endmodule
